// File: src/gla_pkg.sv
// Shared definitions for the gated landmark association block.
// Field widths, kind and register codes, reset values and the multiplier request type.
// Used by every other file of the block; it depends on nothing.
`default_nettype none

package gla_pkg;

    localparam int POS_W   = 24;
    localparam int SCORE_W = 16;
    localparam int TRIG_W  = 16;
    localparam int GATE_W  = 32;
    localparam int IDX_W   = 6;
    localparam int ENTRY_W = 2 * POS_W + SCORE_W;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ASSOC  = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_DISTANCE_SQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE        = 1'd1;

    localparam logic [GATE_W-1:0]         GATE_RST      = 32'd16384;
    localparam logic signed [SCORE_W-1:0] MIN_SCORE_RST = -16'sd512;

    localparam int IN_DATA_W  = 144;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 2;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_req;

endpackage

`default_nettype wire

// File: src/gla_mul.sv
// Shared signed multiplier of the association block, with a registered product.
// Serves the four rotation products and the two squared distance terms.
// Depends on gla_pkg.
`default_nettype none

module gla_mul (
    input  wire                                    i_clk,
    input  gla_pkg::t_mul_req                      i_req,
    output logic signed [gla_pkg::MUL_P_W-1:0]     o_prod
);

    logic signed [gla_pkg::MUL_P_W-1:0] r_prod;
    logic signed [gla_pkg::MUL_P_W-1:0] n_prod;

    always_comb begin
        n_prod = $signed(i_req.a) * $signed(i_req.b);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// File: src/gated_landmark_association_core.sv
// Top level of the gated landmark association block: landmark table, sequencer and result stage.
// Depends on gla_pkg and gla_mul.
//
// Usage. Items arrive on the slave stream; tuser carries the kind (clear, append or
// associate) and tdata the observation, score, pose and heading terms. Every item gives
// exactly one result beat on the master stream. Configuration writes go through the
// cfg channel, which is ready whenever reset is released, and must only be issued while
// the block is idle.
// Sequencing. The block takes one item at a time. A clear, an append or an item of the
// unused kind loads the result and then returns to idle, ready for the next item. An
// association runs the rotation steps; then, if the table holds entries, it reads the top
// one and steps through a dx, a dy and a compare state for each entry scanned from the top
// down, stopping at the first hit; last it loads the result. The single shared multiplier
// sets this pace, since each entry needs two squares and each rotation four.
// Reset. The synchronous active-low reset empties the table, drops any pending result
// and restores the gate and score threshold to their defaults. Table contents need no
// clearing, since only entries below the fill count are ever read.
// Stalls. The result sits in an output register; a new item is accepted while it waits.
// The block then holds its next finished result until the receiver takes the first one.
`default_nettype none

module gated_landmark_association_core #(
    parameter int TABLE_DEPTH = gla_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Slave stream.
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // tdata from bit 0 up: obs_x, obs_y, entry_score, pose_x, pose_y, cos_heading,
    // sin_heading.
    input  wire  [gla_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // tuser from bit 0 up: kind.
    input  wire  [gla_pkg::IN_USER_W-1:0]       i_s_tuser,
    // Master stream.
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // tdata from bit 0 up: match_index, world_x, world_y, two zero bits.
    output logic [gla_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // tuser from bit 0 up: matched, overflow.
    output logic [gla_pkg::OUT_USER_W-1:0]      o_m_tuser,
    // Configuration write channel.
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [gla_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [gla_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int PW = gla_pkg::POS_W;
    localparam int SW = gla_pkg::SCORE_W;
    localparam int PRW = gla_pkg::MUL_P_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_XF   = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_DX   = 3'd3;
    localparam logic [2:0] ST_DY   = 3'd4;
    localparam logic [2:0] ST_CMP  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    localparam logic [2:0] XF_LAST = 3'd5;

    function automatic logic [PW-1:0] sat_pos(input logic signed [PW+4:0] v);
        logic [PW-1:0] res;
        if (v > $signed({{5{1'b0}}, {1'b0, {(PW-1){1'b1}}}})) begin
            res = {1'b0, {(PW-1){1'b1}}};
        end else if (v < $signed({{5{1'b1}}, {1'b1, {(PW-1){1'b0}}}})) begin
            res = {1'b1, {(PW-1){1'b0}}};
        end else begin
            res = v[PW-1:0];
        end
        return res;
    endfunction

    logic [2:0]                  r_state;
    logic [2:0]                  r_step;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    logic [gla_pkg::GATE_W-1:0]  r_gate;
    logic signed [SW-1:0]        r_min_score;

    logic signed [PW-1:0]        r_ox;
    logic signed [PW-1:0]        r_oy;
    logic signed [PW-1:0]        r_px;
    logic signed [PW-1:0]        r_py;
    logic signed [gla_pkg::TRIG_W-1:0] r_cos;
    logic signed [gla_pkg::TRIG_W-1:0] r_sin;
    logic signed [PRW-1:0]       r_acc;
    logic [PW-1:0]               r_wx;
    logic [PW-1:0]               r_wy;
    logic                        r_matched;
    logic [gla_pkg::IDX_W-1:0]   r_midx;
    logic                        r_ovf;

    logic signed [16:0]          r_dy;
    logic                        r_ok;
    logic [32:0]                 r_sq;

    logic [gla_pkg::ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic [gla_pkg::ENTRY_W-1:0] r_rd;

    logic                        r_out_valid;
    logic [gla_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [gla_pkg::OUT_USER_W-1:0] r_out_user;

    logic                        in_fire;
    logic                        full;
    logic [gla_pkg::KIND_W-1:0]  in_kind;
    logic [CW-1:0]               idx_dec;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic signed [PW-1:0]        lm_x;
    logic signed [PW-1:0]        lm_y;
    logic signed [SW-1:0]        lm_s;
    logic signed [PW:0]          dx;
    logic signed [PW:0]          dy;
    logic                        dx_fit;
    logic                        dy_fit;
    logic [33:0]                 dist_sum;
    logic                        hit;
    logic signed [PW+3:0]        rot;
    logic signed [PW+4:0]        wsum_x;
    logic signed [PW+4:0]        wsum_y;
    logic                        out_free;
    gla_pkg::t_mul_req           mul_req;
    logic signed [PRW-1:0]       prod;

    gla_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    assign in_kind    = i_s_tuser[gla_pkg::KIND_W-1:0];
    assign o_s_tready = i_rst_n && (r_state == ST_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign full       = (r_count == CW'(TABLE_DEPTH));
    assign wr_en      = in_fire && (in_kind == gla_pkg::KIND_APPEND) && !full;
    assign idx_dec    = r_idx - CW'(1);
    assign rd_addr    = AW'(idx_dec);
    assign out_free   = !r_out_valid || i_m_tready;
    assign o_cfg_ready = i_rst_n;

    assign lm_x = r_rd[gla_pkg::ENTRY_W-1 -: PW];
    assign lm_y = r_rd[SW +: PW];
    assign lm_s = r_rd[SW-1:0];
    assign dx   = $signed({r_wx[PW-1], r_wx}) - $signed({lm_x[PW-1], lm_x});
    assign dy   = $signed({r_wy[PW-1], r_wy}) - $signed({lm_y[PW-1], lm_y});
    assign dx_fit = (dx[PW:16] == '0) || (dx[PW:16] == '1);
    assign dy_fit = (dy[PW:16] == '0) || (dy[PW:16] == '1);
    assign dist_sum = {1'b0, r_sq} + {1'b0, prod[32:0]};
    assign hit  = r_ok && (dist_sum < {2'b00, r_gate});

    assign rot    = r_acc[PRW-1:14];
    assign wsum_x = $signed({{5{r_px[PW-1]}}, r_px}) + $signed({rot[PW+3], rot});
    assign wsum_y = $signed({{5{r_py[PW-1]}}, r_py}) + $signed({rot[PW+3], rot});

    always_comb begin
        rd_en = 1'b0;
        if (r_state == ST_RD) begin
            rd_en = 1'b1;
        end else if ((r_state == ST_CMP) && !hit && (r_idx != '0)) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        mul_req.a = '0;
        mul_req.b = '0;
        case (r_state)
            ST_XF: begin
                case (r_step)
                    3'd0: begin
                        mul_req.a = gla_pkg::MUL_A_W'(r_ox);
                        mul_req.b = gla_pkg::MUL_B_W'(r_cos);
                    end
                    3'd1: begin
                        mul_req.a = gla_pkg::MUL_A_W'(r_oy);
                        mul_req.b = gla_pkg::MUL_B_W'(r_sin);
                    end
                    3'd2: begin
                        mul_req.a = gla_pkg::MUL_A_W'(r_ox);
                        mul_req.b = gla_pkg::MUL_B_W'(r_sin);
                    end
                    3'd3: begin
                        mul_req.a = gla_pkg::MUL_A_W'(r_oy);
                        mul_req.b = gla_pkg::MUL_B_W'(r_cos);
                    end
                    default: begin
                        mul_req.a = '0;
                        mul_req.b = '0;
                    end
                endcase
            end
            ST_DX: begin
                mul_req.a = dx;
                mul_req.b = dx[16:0];
            end
            ST_DY: begin
                mul_req.a = gla_pkg::MUL_A_W'(r_dy);
                mul_req.b = r_dy;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[AW'(r_count)] <= i_s_tdata[gla_pkg::ENTRY_W-1:0] == '0 ? '0 :
                {i_s_tdata[PW-1:0], i_s_tdata[2*PW-1:PW], i_s_tdata[2*PW+SW-1:2*PW]};
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= gla_pkg::GATE_RST;
            r_min_score <= gla_pkg::MIN_SCORE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gla_pkg::CFG_GATE_DISTANCE_SQ: r_gate <= i_cfg_data;
                gla_pkg::CFG_MIN_SCORE:        r_min_score <= i_cfg_data[SW-1:0];
                default: begin
                    r_gate <= r_gate;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ox  <= i_s_tdata[PW-1:0];
            r_oy  <= i_s_tdata[2*PW-1:PW];
            r_px  <= i_s_tdata[2*PW+SW +: PW];
            r_py  <= i_s_tdata[3*PW+SW +: PW];
            r_cos <= i_s_tdata[4*PW+SW +: gla_pkg::TRIG_W];
            r_sin <= i_s_tdata[4*PW+SW+gla_pkg::TRIG_W +: gla_pkg::TRIG_W];
            r_wx  <= '0;
            r_wy  <= '0;
            r_matched <= 1'b0;
            r_midx    <= '0;
            r_ovf     <= (in_kind == gla_pkg::KIND_APPEND) && full;
            r_idx     <= r_count;
        end
        if (r_state == ST_XF) begin
            case (r_step)
                3'd1: r_acc <= prod + PRW'(8192);
                3'd2: r_acc <= r_acc - prod;
                3'd3: begin
                    r_wx  <= sat_pos(wsum_x);
                    r_acc <= prod + PRW'(8192);
                end
                3'd4: r_acc <= r_acc + prod;
                3'd5: r_wy  <= sat_pos(wsum_y);
                default: r_acc <= r_acc;
            endcase
        end
        if (rd_en) begin
            r_idx <= idx_dec;
        end
        if (r_state == ST_DX) begin
            r_dy <= dy[16:0];
            r_ok <= (lm_s > r_min_score) && dx_fit && dy_fit;
        end
        if (r_state == ST_DY) begin
            r_sq <= prod[32:0];
        end
        if ((r_state == ST_CMP) && hit) begin
            r_matched <= 1'b1;
            r_midx    <= gla_pkg::IDX_W'(r_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_data <= {2'b00, r_wy, r_wx, r_midx};
            r_out_user <= {r_ovf, r_matched};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        case (in_kind)
                            gla_pkg::KIND_CLEAR: begin
                                r_count <= '0;
                                r_state <= ST_FIN;
                            end
                            gla_pkg::KIND_APPEND: begin
                                if (!full) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= ST_FIN;
                            end
                            gla_pkg::KIND_ASSOC: begin
                                r_step  <= '0;
                                r_state <= ST_XF;
                            end
                            default: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_XF: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == XF_LAST) begin
                        r_state <= (r_count == '0) ? ST_FIN : ST_RD;
                    end
                end
                ST_RD: r_state <= ST_DX;
                ST_DX: r_state <= ST_DY;
                ST_DY: r_state <= ST_CMP;
                ST_CMP: begin
                    if (hit || (r_idx == '0)) begin
                        r_state <= ST_FIN;
                    end else begin
                        r_state <= ST_DX;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

// File: src/gla_checker.sv
// Port-level checker for the gated landmark association block, bound to its top level.
// Watches the result stream over time. Depends on gla_pkg and the top level's ports.
`default_nettype none

module gla_checker (
    input wire                                 i_clk,
    input wire                                 i_rst_n,
    input wire                                 o_m_tvalid,
    input wire                                 i_m_tready,
    input wire [gla_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    input wire [gla_pkg::OUT_USER_W-1:0]       o_m_tuser
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("Result beat changed while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("Result beat present right after reset.");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("Result beat is both matched and overflowed.");

    a_nomatch_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> (o_m_tdata[gla_pkg::IDX_W-1:0] == '0))
        else $error("Unmatched result beat carries a nonzero index.");

    a_overflow_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> (o_m_tdata == '0))
        else $error("Refused append produced nonzero data.");

endmodule

bind gated_landmark_association_core gla_checker u_gla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for gated_landmark_association_core: directed and random item streams with a
// local prediction of every result beat, checked field by field on the master stream.
// Depends on gla_pkg and the block's RTL only.
module tb;

    localparam int LM_DEPTH = gla_pkg::TABLE_DEPTH_DEF;
    localparam logic [gla_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam longint POS_HI = 8388607;
    localparam longint POS_LO = -8388608;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 210;

    typedef struct {
        logic [gla_pkg::KIND_W-1:0]         kind;
        logic signed [gla_pkg::POS_W-1:0]   obs_x;
        logic signed [gla_pkg::POS_W-1:0]   obs_y;
        logic signed [gla_pkg::SCORE_W-1:0] score;
        logic signed [gla_pkg::POS_W-1:0]   pose_x;
        logic signed [gla_pkg::POS_W-1:0]   pose_y;
        logic signed [gla_pkg::TRIG_W-1:0]  cos_h;
        logic signed [gla_pkg::TRIG_W-1:0]  sin_h;
    } t_obs_item;

    typedef struct {
        logic                             matched;
        logic [gla_pkg::IDX_W-1:0]        match_index;
        logic signed [gla_pkg::POS_W-1:0] world_x;
        logic signed [gla_pkg::POS_W-1:0] world_y;
        logic                             overflow;
    } t_assoc_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic [gla_pkg::IN_DATA_W-1:0] i_s_tdata = '0;
    logic [gla_pkg::IN_USER_W-1:0] i_s_tuser = '0;
    logic i_m_tready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [gla_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [gla_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic o_s_tready;
    logic o_m_tvalid;
    logic [gla_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [gla_pkg::OUT_USER_W-1:0] o_m_tuser;
    logic o_cfg_ready;

    logic signed [gla_pkg::POS_W-1:0]   lm_x [LM_DEPTH];
    logic signed [gla_pkg::POS_W-1:0]   lm_y [LM_DEPTH];
    logic signed [gla_pkg::SCORE_W-1:0] lm_score [LM_DEPTH];
    int lm_count = 0;
    logic [gla_pkg::GATE_W-1:0] gate_sq = gla_pkg::GATE_RST;
    logic signed [gla_pkg::SCORE_W-1:0] min_score = gla_pkg::MIN_SCORE_RST;

    t_assoc_result pending_results [$];
    int error_count = 0;
    int items_sent = 0;
    int cycle_count = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 30;

    gated_landmark_association_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic signed [gla_pkg::POS_W-1:0] clamp_pos(input longint v);
        longint c;
        c = (v > POS_HI) ? POS_HI : ((v < POS_LO) ? POS_LO : v);
        return c[gla_pkg::POS_W-1:0];
    endfunction

    // Rotation by the heading terms with round-half-up and a floor shift.
    function automatic void rotate_point(input logic signed [gla_pkg::POS_W-1:0] ox, oy,
                                         input logic signed [gla_pkg::TRIG_W-1:0] c, s,
                                         output longint rx, ry);
        rx = (longint'(ox) * longint'(c) - longint'(oy) * longint'(s) + 8192) >>> 14;
        ry = (longint'(ox) * longint'(s) + longint'(oy) * longint'(c) + 8192) >>> 14;
    endfunction

    function automatic t_assoc_result predict_result(input t_obs_item it);
        t_assoc_result res;
        longint rx, ry, dx, dy, dist_sq;
        int i;
        res.matched = 1'b0;
        res.match_index = '0;
        res.world_x = '0;
        res.world_y = '0;
        res.overflow = 1'b0;
        case (it.kind)
            gla_pkg::KIND_CLEAR: begin
                lm_count = 0;
            end
            gla_pkg::KIND_APPEND: begin
                if (lm_count < LM_DEPTH) begin
                    lm_x[lm_count] = it.obs_x;
                    lm_y[lm_count] = it.obs_y;
                    lm_score[lm_count] = it.score;
                    lm_count++;
                end else begin
                    res.overflow = 1'b1;
                end
            end
            gla_pkg::KIND_ASSOC: begin
                rotate_point(it.obs_x, it.obs_y, it.cos_h, it.sin_h, rx, ry);
                res.world_x = clamp_pos(longint'(it.pose_x) + rx);
                res.world_y = clamp_pos(longint'(it.pose_y) + ry);
                // The highest filled index wins among qualifying entries.
                for (i = lm_count - 1; i >= 0 && !res.matched; i--) begin
                    if (lm_score[i] > min_score) begin
                        dx = longint'(res.world_x) - longint'(lm_x[i]);
                        dy = longint'(res.world_y) - longint'(lm_y[i]);
                        dist_sq = dx * dx + dy * dy;
                        if (dist_sq < longint'(gate_sq)) begin
                            res.matched = 1'b1;
                            res.match_index = i[gla_pkg::IDX_W-1:0];
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] expected,
                                        input logic signed [63:0] actual);
        if (actual !== expected) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_assoc_result exp_res;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("Result beat arrived with no item waiting for it.");
                error_count++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("matched", exp_res.matched, o_m_tuser[0]);
                check_field("overflow", exp_res.overflow, o_m_tuser[1]);
                check_field("match_index", exp_res.match_index, o_m_tdata[5:0]);
                check_field("world_x", exp_res.world_x, $signed(o_m_tdata[29:6]));
                check_field("world_y", exp_res.world_y, $signed(o_m_tdata[53:30]));
                check_field("pad", 0, o_m_tdata[55:54]);
            end
        end
    end

    function automatic t_obs_item make_item(input logic [gla_pkg::KIND_W-1:0] kind,
                                            input longint ox, oy, sc, px, py, c, s);
        t_obs_item it;
        it.kind = kind;
        it.obs_x = ox[gla_pkg::POS_W-1:0];
        it.obs_y = oy[gla_pkg::POS_W-1:0];
        it.score = sc[gla_pkg::SCORE_W-1:0];
        it.pose_x = px[gla_pkg::POS_W-1:0];
        it.pose_y = py[gla_pkg::POS_W-1:0];
        it.cos_h = c[gla_pkg::TRIG_W-1:0];
        it.sin_h = s[gla_pkg::TRIG_W-1:0];
        return it;
    endfunction

    function automatic longint rand_pos_full();
        return longint'($urandom_range(0, 16777215)) - 8388608;
    endfunction

    function automatic longint rand_pos_region();
        return longint'($urandom_range(0, 262143)) - 131072;
    endfunction

    function automatic longint rand_trig();
        if ($urandom_range(0, 3) == 0) begin
            return longint'($urandom_range(0, 4)) * 8192 - 16384;
        end
        return longint'($urandom_range(0, 32768)) - 16384;
    endfunction

    function automatic longint rand_score();
        case ($urandom_range(0, 9))
            0: return longint'(min_score);
            1: return longint'(min_score) + 1;
            default: return longint'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic t_obs_item random_item();
        return make_item(gla_pkg::KIND_W'($urandom_range(0, 3)), rand_pos_full(),
                         rand_pos_full(), longint'($urandom_range(0, 65535)) - 32768,
                         rand_pos_full(), rand_pos_full(), rand_trig(), rand_trig());
    endfunction

    task automatic send_item(input t_obs_item it);
        t_assoc_result exp_res;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= it.kind;
        i_s_tdata <= {it.sin_h, it.cos_h, it.pose_y, it.pose_x, it.score, it.obs_y, it.obs_x};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        exp_res = predict_result(it);
        pending_results.insert(pending_results.size(), exp_res);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [gla_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [gla_pkg::CFG_DATA_W-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == gla_pkg::CFG_GATE_DISTANCE_SQ) begin
            gate_sq = value;
        end else begin
            min_score = value[gla_pkg::SCORE_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic assoc_at(input longint wx, input longint wy);
        send_item(make_item(gla_pkg::KIND_ASSOC, wx, wy, 0, 0, 0, 16384, 0));
    endtask

    // Chooses an observation and heading, then the pose that lands the point on the target.
    task automatic send_assoc_toward(input longint tx, input longint ty);
        t_obs_item it;
        longint rx, ry;
        if ($urandom_range(0, 9) == 0) begin
            it = make_item(gla_pkg::KIND_ASSOC, rand_pos_full(), rand_pos_full(), rand_score(),
                           0, 0, rand_trig(), rand_trig());
        end else begin
            it = make_item(gla_pkg::KIND_ASSOC, rand_pos_region(), rand_pos_region(),
                           rand_score(), 0, 0, rand_trig(), rand_trig());
        end
        rotate_point(it.obs_x, it.obs_y, it.cos_h, it.sin_h, rx, ry);
        it.pose_x = clamp_pos(tx - rx);
        it.pose_y = clamp_pos(ty - ry);
        send_item(it);
    endtask

    task automatic test_directed_cases();
        send_item(make_item(gla_pkg::KIND_ASSOC, POS_HI, POS_HI, 32767, POS_HI, POS_HI,
                            16384, 0));
        send_item(make_item(gla_pkg::KIND_ASSOC, POS_LO, POS_LO, -32768, POS_LO, POS_LO,
                            16384, 16384));
        send_item(make_item(gla_pkg::KIND_ASSOC, 1, -1, 0, 0, 0, 8192, -8192));
        send_item(make_item(gla_pkg::KIND_ASSOC, POS_HI, POS_LO, 0, POS_LO, POS_HI,
                            -16384, -16384));
        send_item(make_item(KIND_UNUSED, -1, -1, -1, -1, -1, -1, -1));
        send_item(make_item(gla_pkg::KIND_CLEAR, 12345, -6789, 100, 1, 2, 3, 4));
        send_item(make_item(gla_pkg::KIND_APPEND, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(gla_pkg::KIND_APPEND, 0, 0, -512, 0, 0, 0, 0));
        send_item(make_item(gla_pkg::KIND_APPEND, 100, 0, 32767, 0, 0, 0, 0));
        assoc_at(128, 0);
        assoc_at(-127, 0);
        assoc_at(-128, 0);
        send_item(make_item(gla_pkg::KIND_APPEND, 0, 0, -32768, 0, 0, 0, 0));
        assoc_at(0, 0);
        send_item(make_item(gla_pkg::KIND_APPEND, 5, 5, -511, 0, 0, 0, 0));
        assoc_at(0, 0);
        send_item(make_item(gla_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        assoc_at(0, 0);
        send_item(make_item(gla_pkg::KIND_APPEND, POS_HI, POS_LO, 0, 0, 0, 0, 0));
        assoc_at(POS_HI, POS_LO);
    endtask

    task automatic test_table_full();
        int k;
        send_item(make_item(gla_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        for (k = 0; k < LM_DEPTH + 2; k++) begin
            send_item(make_item(gla_pkg::KIND_APPEND, k * 1024 - 32768, 4096 - k * 512, k * 8,
                                0, 0, 0, 0));
        end
        assoc_at(63 * 1024 - 32768, 4096 - 63 * 512);
        assoc_at(-32768, 4096);
        assoc_at(10 * 1024 - 32768 + 50, 4096 - 10 * 512 + 50);
    endtask

    task automatic test_register_extremes();
        write_register(gla_pkg::CFG_GATE_DISTANCE_SQ, '0);
        assoc_at(5 * 1024 - 32768, 4096 - 5 * 512);
        write_register(gla_pkg::CFG_GATE_DISTANCE_SQ, '1);
        assoc_at(5 * 1024 - 32768 + 60000, 4096 - 5 * 512);
        write_register(gla_pkg::CFG_MIN_SCORE, 32'h0000_7FFF);
        assoc_at(5 * 1024 - 32768, 4096 - 5 * 512);
        write_register(gla_pkg::CFG_MIN_SCORE, 32'h0000_8000);
        assoc_at(5 * 1024 - 32768, 4096 - 5 * 512);
        send_item(make_item(gla_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(gla_pkg::KIND_APPEND, 0, 0, -32768, 0, 0, 0, 0));
        send_item(make_item(gla_pkg::KIND_APPEND, 4194304, 4194304, 32767, 0, 0, 0, 0));
        assoc_at(0, 0);
        assoc_at(4194304, 4194304);
    endtask

    task automatic test_random_traffic(input int n_items, input int send_pct, input int recv_pct);
        int target, pause_at, radius, n_app, n_assoc, k, j, pick;
        bit paused;
        longint tx, ty;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        radius = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(65, 4000);
        write_register(gla_pkg::CFG_GATE_DISTANCE_SQ, radius * radius);
        write_register(gla_pkg::CFG_MIN_SCORE, $urandom_range(0, 2048) - 1024);
        target = items_sent + n_items;
        pause_at = items_sent + n_items / 2;
        paused = 1'b0;
        while (items_sent < target) begin
            if (!paused && items_sent >= pause_at) begin
                wait_idle();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 12) begin
                repeat ($urandom_range(1, 6)) send_item(random_item());
            end else begin
                send_item(make_item(gla_pkg::KIND_CLEAR, rand_pos_full(), rand_pos_full(),
                                    rand_score(), rand_pos_full(), rand_pos_full(),
                                    rand_trig(), rand_trig()));
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    n_app = $urandom_range(0, 12);
                end else if (pick < 95) begin
                    n_app = $urandom_range(13, 40);
                end else begin
                    n_app = $urandom_range(60, 66);
                end
                for (k = 0; k < n_app; k++) begin
                    if (lm_count > 0 && $urandom_range(0, 2) == 0) begin
                        // Clustered entries exercise the top-down priority.
                        j = $urandom_range(0, (lm_count < LM_DEPTH ? lm_count : LM_DEPTH) - 1);
                        tx = longint'(lm_x[j]) + longint'($urandom_range(0, 4 * radius))
                             - 2 * radius;
                        ty = longint'(lm_y[j]) + longint'($urandom_range(0, 4 * radius))
                             - 2 * radius;
                    end else begin
                        tx = rand_pos_region();
                        ty = rand_pos_region();
                    end
                    send_item(make_item(gla_pkg::KIND_APPEND, tx, ty, rand_score(),
                                        rand_pos_full(), rand_pos_full(), rand_trig(),
                                        rand_trig()));
                end
                n_assoc = $urandom_range(3, 16);
                for (k = 0; k < n_assoc; k++) begin
                    pick = $urandom_range(0, 99);
                    if (lm_count > 0 && pick < 65) begin
                        j = $urandom_range(0, (lm_count < LM_DEPTH ? lm_count : LM_DEPTH) - 1);
                        if (pick < 7) begin
                            tx = longint'(lm_x[j]) + radius;
                            ty = longint'(lm_y[j]);
                        end else begin
                            tx = longint'(lm_x[j]) + longint'($urandom_range(0, 2 * radius + 2))
                                 - (radius + 1);
                            ty = longint'(lm_y[j]) + longint'($urandom_range(0, 2 * radius + 2))
                                 - (radius + 1);
                        end
                    end else begin
                        tx = rand_pos_region();
                        ty = rand_pos_region();
                    end
                    send_assoc_toward(tx, ty);
                    if ($urandom_range(0, 19) == 0) begin
                        send_item(make_item(gla_pkg::KIND_APPEND, tx, ty, rand_score(),
                                            0, 0, 0, 0));
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_table_full();
        test_register_extremes();
        test_random_traffic(570, 28, 69);
        test_random_traffic(570, 69, 28);
        test_random_traffic(560, 0, 0);
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
